[sv/ptsu_pkg.sv]
// Shared types and codes of the periodic task scheduler unit.
// No dependencies; the top level and the testbench import this package.
`default_nettype none

package ptsu_pkg;

  // Request codes carried by req_type.
  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_START = 2'd1,
    REQ_TICK  = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  // Scheduling policies held in the policy register.
  typedef enum logic [1:0] {
    POL_RM   = 2'd0,
    POL_EDF  = 2'd1,
    POL_LLF  = 2'd2,
    POL_FIFO = 2'd3
  } policy_t;

  // Configuration register indexes.
  localparam logic CFG_POLICY     = 1'b0;
  localparam logic CFG_TASK_COUNT = 1'b1;

  // Sequencer states.
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_HEAD,
    ST_SHIFT,
    ST_T_LOOP,
    ST_T_GET,
    ST_REL_GO,
    ST_REL_WAIT,
    ST_PUSH,
    ST_GCD_STEP,
    ST_GCD_WAIT,
    ST_LCM_WAIT,
    ST_LCM_MUL,
    ST_LCM_SET,
    ST_NEXT,
    ST_SORT,
    ST_PR_UPD,
    ST_XS_HEAD,
    ST_XS_CMP,
    ST_XS_END,
    ST_FINISH
  } state_t;

endpackage

`default_nettype wire

[sv/periodic_task_scheduler_unit.sv]
// Top level of the periodic task scheduler unit: sequencer, divider and queue logic.
// Depends on ptsu_pkg and on ptsu_ram for the task table and the ready queue.
`default_nettype none

// The block keeps a table of periodic tasks and a ready queue of jobs, and
// schedules them by rate monotonic, earliest deadline, least laxity or FIFO
// order. A command is taken when start is high and busy is low. A load
// command writes one task table entry. A start command queues one job per
// active task, computes the hyperperiod with a shared restoring divider
// (Euclid steps for each task) and sorts unless the policy is FIFO. A tick
// command is the only one that returns a transaction: done is high for
// exactly one cycle with the result ports valid, and the receiver cannot
// hold it off, so it must take the result in that cycle. A tick charges the
// head job, retiring it and shifting the queue once it completes, runs the
// divider once per active task for the release test, pushes each released
// job and, unless the policy is FIFO, refreshes the priorities and runs an
// exchange sort at one compare per cycle on the queue memory's read port.
// The ready queue memory's single read port and the divider set its speed.
// Once the missed or finished flag is set a tick returns its result in the
// next cycle without changing any state.
module periodic_task_scheduler_unit #(
  parameter int MAX_TASKS   = 8,
  parameter int QUEUE_DEPTH = 16,
  parameter int TIME_WIDTH  = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  req_type,
  input  wire logic [2:0]  task_slot,
  input  wire logic [15:0] task_period,
  input  wire logic [15:0] task_compute,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [3:0]  cfg_data,
  output logic             done,
  output logic [2:0]       running_task,
  output logic             cpu_idle,
  output logic             deadline_missed,
  output logic             finished,
  output logic [15:0]      current_time
);

  import ptsu_pkg::*;

  localparam int TW  = TIME_WIDTH;
  localparam int IDW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CW  = $clog2(MAX_TASKS + 1);
  localparam int QAW = $clog2(QUEUE_DEPTH);
  localparam int FW  = $clog2(QUEUE_DEPTH + 1);
  localparam int PW  = TW + 3;
  localparam int DCW = $clog2(TW + 1);
  localparam logic [TW-1:0] TIME_MAX = '1;

  // One queued job. The priority is signed so that laxity may go negative.
  typedef struct packed {
    logic [IDW-1:0]       id;
    logic [TW-1:0]        period;
    logic [TW-1:0]        compute;
    logic [TW-1:0]        remaining;
    logic [TW-1:0]        rel_time;
    logic signed [PW-1:0] prio;
  } entry_t;

  localparam int EW = $bits(entry_t);

  state_t state, state_next;

  logic [1:0]           policy;
  logic [3:0]           task_count;
  logic [CW-1:0]        n_act;
  logic [FW-1:0]        fill;
  logic [TW-1:0]        elapsed;
  logic [TW-1:0]        hyper;
  logic                 missed;
  logic                 fin;
  logic                 sat;
  logic                 is_tick;
  logic [MAX_TASKS-1:0] present;
  logic [CW-1:0]        tix;
  logic [FW-1:0]        qi;
  logic [FW-1:0]        qj;
  entry_t               cur;
  logic [TW-1:0]        tbl_p;
  logic [TW-1:0]        tbl_c;
  logic [TW-1:0]        gcd_a;
  logic [TW-1:0]        gcd_b;
  logic [2*TW-1:0]      prod;
  logic [IDW-1:0]       head_id;
  logic                 head_idle;

  // Restoring divider shared by the release test and the hyperperiod math.
  logic                 div_run;
  logic [DCW-1:0]       div_cnt;
  logic [TW:0]          div_rem;
  logic [TW-1:0]        div_quo;
  logic [TW-1:0]        div_den;
  logic                 div_go;
  logic [TW-1:0]        div_num_in;
  logic [TW-1:0]        div_den_in;
  logic [TW:0]          div_shift;

  // Memory ports.
  logic                 q_we;
  logic [QAW-1:0]       q_waddr;
  entry_t               q_wdata;
  logic [QAW-1:0]       q_raddr;
  logic [EW-1:0]        q_rdata;
  entry_t               q_rd;
  logic                 t_we;
  logic [IDW-1:0]       t_waddr;
  logic [2*TW-1:0]      t_wdata;
  logic [IDW-1:0]       t_raddr;
  logic [2*TW-1:0]      t_rdata;

  logic                 accept;
  logic                 slot_ok;
  logic [IDW+2:0]       slot_wide;
  logic [TW+15:0]       per_wide;
  logic [TW+15:0]       comp_wide;
  logic [IDW+2:0]       head_wide;
  logic [TW+15:0]       time_wide;
  logic [TW-1:0]        rem_dec;
  logic                 pop;
  entry_t               new_e;
  entry_t               upd_e;
  logic                 lower;
  logic [TW-1:0]        rd_p;
  logic [TW-1:0]        rd_c;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  assign n_act = (32'(task_count) > MAX_TASKS) ? CW'(MAX_TASKS) : CW'(task_count);

  // Field width adaptation between the fixed ports and the time width.
  assign slot_wide = {IDW'(0), task_slot};
  assign slot_ok   = (32'(task_slot) < MAX_TASKS);
  assign per_wide  = {TW'(0), task_period};
  assign comp_wide = {TW'(0), task_compute};
  assign head_wide = {3'b000, head_id};
  assign time_wide = {16'h0000, elapsed};

  assign q_rd    = entry_t'(q_rdata);
  assign rem_dec = (q_rd.remaining != '0) ? q_rd.remaining - TW'(1) : q_rd.remaining;
  assign pop     = (rem_dec == '0);
  assign lower   = ($signed(q_rd.prio) < $signed(cur.prio));

  // A zero period or compute time counts as one tick.
  assign rd_p = (t_rdata[TW-1:0] == '0) ? TW'(1) : t_rdata[TW-1:0];
  assign rd_c = (t_rdata[2*TW-1:TW] == '0) ? TW'(1) : t_rdata[2*TW-1:TW];

  always_comb begin
    new_e.id        = tix[IDW-1:0];
    new_e.period    = tbl_p;
    new_e.compute   = tbl_c;
    new_e.remaining = tbl_c;
    new_e.rel_time  = elapsed;
    new_e.prio      = $signed({3'b000, tbl_p});
  end

  // Priority refresh applied to each queued job before the sort.
  always_comb begin
    upd_e = q_rd;
    case (policy_t'(policy))
      POL_RM: begin
        upd_e.prio = $signed({3'b000, q_rd.period});
      end
      POL_EDF: begin
        if ($signed(q_rd.prio) > $signed(PW'(0))) begin
          upd_e.prio = q_rd.prio - PW'(1);
        end
      end
      POL_LLF: begin
        upd_e.prio = $signed({3'b000, q_rd.rel_time}) + $signed({3'b000, q_rd.period})
                   - $signed({3'b000, elapsed}) - $signed({3'b000, q_rd.compute});
      end
      default: begin
        upd_e = q_rd;
      end
    endcase
  end

  // Next state and memory/divider controls.
  always_comb begin
    state_next = state;
    q_we       = 1'b0;
    q_waddr    = qi[QAW-1:0];
    q_wdata    = cur;
    q_raddr    = '0;
    t_we       = 1'b0;
    t_waddr    = slot_wide[IDW-1:0];
    t_wdata    = {comp_wide[TW-1:0], per_wide[TW-1:0]};
    t_raddr    = tix[IDW-1:0];
    div_go     = 1'b0;
    div_num_in = elapsed;
    div_den_in = tbl_p;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (req_t'(req_type))
            REQ_LOAD: begin
              t_we = slot_ok;
            end
            REQ_START: begin
              state_next = ST_T_LOOP;
            end
            REQ_TICK: begin
              if (!missed && !fin) begin
                state_next = (fill != '0) ? ST_HEAD : ST_T_LOOP;
              end
            end
            REQ_NONE: begin
              state_next = ST_IDLE;
            end
          endcase
        end
      end
      ST_HEAD: begin
        if (!pop) begin
          q_we            = 1'b1;
          q_waddr         = '0;
          q_wdata         = q_rd;
          q_wdata.remaining = rem_dec;
          state_next      = ST_T_LOOP;
        end else if (fill > FW'(1)) begin
          q_raddr    = QAW'(1);
          state_next = ST_SHIFT;
        end else begin
          state_next = ST_T_LOOP;
        end
      end
      ST_SHIFT: begin
        // fill already leaves out the retired head; entries 1..fill move down.
        q_we    = 1'b1;
        q_waddr = QAW'(qj - FW'(1));
        q_wdata = q_rd;
        if (qj == fill) begin
          state_next = ST_T_LOOP;
        end else begin
          q_raddr = QAW'(qj + FW'(1));
        end
      end
      ST_T_LOOP: begin
        state_next = (tix < n_act) ? ST_T_GET : ST_SORT;
      end
      ST_T_GET: begin
        state_next = is_tick ? ST_REL_GO : ST_PUSH;
      end
      ST_REL_GO: begin
        div_go     = 1'b1;
        state_next = ST_REL_WAIT;
      end
      ST_REL_WAIT: begin
        if (!div_run) begin
          state_next = (div_rem == '0) ? ST_PUSH : ST_NEXT;
        end
      end
      ST_PUSH: begin
        if (fill < FW'(QUEUE_DEPTH)) begin
          q_we    = 1'b1;
          q_waddr = fill[QAW-1:0];
          q_wdata = new_e;
        end
        state_next = (!is_tick && !sat) ? ST_GCD_STEP : ST_NEXT;
      end
      ST_GCD_STEP: begin
        div_go = 1'b1;
        if (gcd_b == '0) begin
          div_num_in = hyper;
          div_den_in = gcd_a;
          state_next = ST_LCM_WAIT;
        end else begin
          div_num_in = gcd_a;
          div_den_in = gcd_b;
          state_next = ST_GCD_WAIT;
        end
      end
      ST_GCD_WAIT: begin
        if (!div_run) begin
          state_next = ST_GCD_STEP;
        end
      end
      ST_LCM_WAIT: begin
        if (!div_run) begin
          state_next = ST_LCM_MUL;
        end
      end
      ST_LCM_MUL: begin
        state_next = ST_LCM_SET;
      end
      ST_LCM_SET: begin
        state_next = ST_NEXT;
      end
      ST_NEXT: begin
        state_next = ST_T_LOOP;
      end
      ST_SORT: begin
        if (policy_t'(policy) == POL_FIFO || fill == '0) begin
          state_next = ST_FINISH;
        end else begin
          state_next = ST_PR_UPD;
        end
      end
      ST_PR_UPD: begin
        q_we    = 1'b1;
        q_wdata = upd_e;
        if ({1'b0, qi} + (FW+1)'(1) < {1'b0, fill}) begin
          q_raddr = QAW'(qi + FW'(1));
        end else if (fill > FW'(1)) begin
          state_next = ST_XS_HEAD;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_XS_HEAD: begin
        q_raddr    = QAW'(qi + FW'(1));
        state_next = ST_XS_CMP;
      end
      ST_XS_CMP: begin
        if (lower) begin
          q_we    = 1'b1;
          q_waddr = qj[QAW-1:0];
          q_wdata = cur;
        end
        if ({1'b0, qj} + (FW+1)'(1) < {1'b0, fill}) begin
          q_raddr = QAW'(qj + FW'(1));
        end else begin
          state_next = ST_XS_END;
        end
      end
      ST_XS_END: begin
        q_we    = 1'b1;
        q_wdata = cur;
        if ({1'b0, qi} + (FW+1)'(2) < {1'b0, fill}) begin
          q_raddr    = QAW'(qi + FW'(1));
          state_next = ST_XS_HEAD;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign div_shift = {div_rem[TW-1:0], div_quo[TW-1]};

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      policy     <= '0;
      task_count <= 4'd1;
      fill       <= '0;
      elapsed    <= '0;
      hyper      <= TW'(1);
      missed     <= 1'b0;
      fin        <= 1'b0;
      sat        <= 1'b0;
      is_tick    <= 1'b0;
      present    <= '0;
      done       <= 1'b0;
      div_run    <= 1'b0;
    end else begin
      done <= 1'b0;

      if (cfg_we) begin
        case (cfg_index)
          CFG_POLICY:     policy <= cfg_data[1:0];
          CFG_TASK_COUNT: task_count <= cfg_data;
          default:        policy <= policy;
        endcase
      end

      if (div_go) begin
        div_run <= 1'b1;
        div_cnt <= DCW'(TW);
        div_rem <= '0;
        div_quo <= div_num_in;
        div_den <= div_den_in;
      end else if (div_run) begin
        if (div_shift >= {1'b0, div_den}) begin
          div_rem <= div_shift - {1'b0, div_den};
          div_quo <= {div_quo[TW-2:0], 1'b1};
        end else begin
          div_rem <= div_shift;
          div_quo <= {div_quo[TW-2:0], 1'b0};
        end
        div_cnt <= div_cnt - DCW'(1);
        if (div_cnt == DCW'(1)) begin
          div_run <= 1'b0;
        end
      end

      case (state)
        ST_IDLE: begin
          if (accept && req_t'(req_type) == REQ_START) begin
            fill    <= '0;
            elapsed <= '0;
            hyper   <= TW'(1);
            missed  <= 1'b0;
            fin     <= 1'b0;
            sat     <= 1'b0;
            present <= '0;
            tix     <= '0;
            is_tick <= 1'b0;
          end else if (accept && req_t'(req_type) == REQ_TICK) begin
            if (missed || fin) begin
              // Frozen after a flag: report idle with the held time.
              done            <= 1'b1;
              running_task    <= 3'd0;
              cpu_idle        <= 1'b1;
              deadline_missed <= missed;
              finished        <= fin;
              current_time    <= time_wide[15:0];
            end else begin
              elapsed   <= elapsed + TW'(1);
              is_tick   <= 1'b1;
              tix       <= '0;
              head_id   <= '0;
              head_idle <= 1'b1;
            end
          end
        end
        ST_HEAD: begin
          head_id   <= q_rd.id;
          head_idle <= 1'b0;
          if (pop) begin
            present[q_rd.id] <= 1'b0;
            fill             <= fill - FW'(1);
            qj               <= FW'(1);
          end
        end
        ST_SHIFT: begin
          qj <= qj + FW'(1);
        end
        ST_T_LOOP: begin
          if (!(tix < n_act) && is_tick && elapsed == hyper) begin
            fin <= 1'b1;
          end
        end
        ST_T_GET: begin
          tbl_p <= rd_p;
          tbl_c <= rd_c;
        end
        ST_PUSH: begin
          if (fill < FW'(QUEUE_DEPTH)) begin
            fill                 <= fill + FW'(1);
            present[tix[IDW-1:0]] <= 1'b1;
            // A second job of one task in the queue means a missed deadline.
            if (present[tix[IDW-1:0]]) begin
              missed <= 1'b1;
            end
          end
          gcd_a <= hyper;
          gcd_b <= tbl_p;
        end
        ST_GCD_WAIT: begin
          if (!div_run) begin
            gcd_a <= gcd_b;
            gcd_b <= div_rem[TW-1:0];
          end
        end
        ST_LCM_MUL: begin
          prod <= (2*TW)'(div_quo) * (2*TW)'(tbl_p);
        end
        ST_LCM_SET: begin
          if (prod > (2*TW)'(TIME_MAX)) begin
            hyper <= TIME_MAX;
            sat   <= 1'b1;
          end else begin
            hyper <= prod[TW-1:0];
          end
        end
        ST_NEXT: begin
          tix <= tix + CW'(1);
        end
        ST_SORT: begin
          qi <= '0;
        end
        ST_PR_UPD: begin
          if ({1'b0, qi} + (FW+1)'(1) < {1'b0, fill}) begin
            qi <= qi + FW'(1);
          end else begin
            qi <= '0;
          end
        end
        ST_XS_HEAD: begin
          cur <= q_rd;
          qj  <= qi + FW'(1);
        end
        ST_XS_CMP: begin
          if (lower) begin
            cur <= q_rd;
          end
          qj <= qj + FW'(1);
        end
        ST_XS_END: begin
          qi <= qi + FW'(1);
        end
        ST_FINISH: begin
          if (is_tick) begin
            done            <= 1'b1;
            running_task    <= head_wide[2:0];
            cpu_idle        <= head_idle;
            deadline_missed <= missed;
            finished        <= fin;
            current_time    <= time_wide[15:0];
          end
        end
        default: begin
          is_tick <= is_tick;
        end
      endcase
    end
  end

  ptsu_ram #(
    .WIDTH (2 * TW),
    .DEPTH (MAX_TASKS)
  ) u_task_ram (
    .clk   (clk),
    .we    (t_we),
    .waddr (t_waddr),
    .wdata (t_wdata),
    .raddr (t_raddr),
    .rdata (t_rdata)
  );

  ptsu_ram #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

  // The queue never holds more jobs than it has entries.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FW'(QUEUE_DEPTH))
    else $error("ready queue fill exceeds its depth");

  // A result transaction is only shown once the sequencer is back at rest.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while a command is still in progress");

  // The shared divider is never restarted while it is still iterating.
  a_div_free: assert property (@(posedge clk) disable iff (rst)
    div_go |-> !div_run)
    else $error("divider started while busy");

endmodule

`default_nettype wire

[sv/ptsu_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
// Used for the task table and the ready queue; no package dependencies.
`default_nettype none

module ptsu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[sim/tb_periodic_task_scheduler_unit.sv]
// Self-checking testbench for periodic_task_scheduler_unit.
// Depends on ptsu_pkg and the scheduler RTL; holds its own scheduler model.
`timescale 1ns / 100ps

module tb_periodic_task_scheduler_unit;
  import ptsu_pkg::*;

  // Clock, reset and the ports of the unit under test.
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  req_type = REQ_NONE;
  logic [2:0]  task_slot = '0;
  logic [15:0] task_period = '0;
  logic [15:0] task_compute = '0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = CFG_POLICY;
  logic [3:0]  cfg_data = '0;
  logic        done;
  logic [2:0]  running_task;
  logic        cpu_idle;
  logic        deadline_missed;
  logic        finished;
  logic [15:0] current_time;

  periodic_task_scheduler_unit uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req_type(req_type), .task_slot(task_slot), .task_period(task_period),
    .task_compute(task_compute), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .done(done), .running_task(running_task),
    .cpu_idle(cpu_idle), .deadline_missed(deadline_missed),
    .finished(finished), .current_time(current_time)
  );

  always #5 clk = ~clk;

  // The stimulus plan is a list of steps: a command transaction, a register
  // write, or a drain that holds the driver until the unit is idle and every
  // expected tick report has arrived.
  typedef enum {STEP_CMD, STEP_CFG, STEP_DRAIN} step_kind_t;

  typedef struct {
    step_kind_t  kind;
    logic [1:0]  req;
    logic [2:0]  slot;
    logic [15:0] period;
    logic [15:0] compute;
    logic        reg_index;
    logic [3:0]  reg_value;
    bit          quiet;      // no idle burst after this command
  } plan_step_t;

  // One tick report as the unit should produce it.
  typedef struct {
    logic [2:0]  run_id;
    logic        idle;
    logic        missed;
    logic        fin;
    logic [15:0] now;
  } tick_report_t;

  // A queued job of the scheduler model.
  typedef struct {
    logic [2:0] id;
    longint     period;
    longint     compute;
    longint     remaining;
    longint     rel_tick;
    longint     prio;
  } job_t;

  plan_step_t   plan[$];
  tick_report_t expected_reports[$];

  // Scheduler model state.
  longint  period_tab[8];
  longint  compute_tab[8];
  job_t    ready_q[16];
  int      ready_fill;
  longint  now_ticks;
  longint  hyper_len;
  bit      miss_seen;
  bit      end_seen;
  policy_t sched_policy;
  int      task_num;

  int  mismatches = 0;
  int  reports_seen = 0;
  int  cmds_sent = 0;
  int  phases_run = 0;
  bit  all_sent = 1'b0;

  function automatic int active_count();
    return (task_num > 8) ? 8 : task_num;
  endfunction

  function automatic longint period_of(int i);
    return (period_tab[i] == 0) ? 1 : period_tab[i];
  endfunction

  function automatic longint compute_of(int i);
    return (compute_tab[i] == 0) ? 1 : compute_tab[i];
  endfunction

  function automatic longint gcd(longint a, longint b);
    longint t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  // Recompute priorities for the current policy and reorder the queue with
  // the same exchange sort as the hardware, so that ties land identically.
  function automatic void reorder_ready();
    job_t t;
    case (sched_policy)
      POL_RM: begin
        for (int i = 0; i < ready_fill; i++) ready_q[i].prio = ready_q[i].period;
      end
      POL_EDF: begin
        for (int i = 0; i < ready_fill; i++)
          if (ready_q[i].prio > 0) ready_q[i].prio--;
      end
      POL_LLF: begin
        for (int i = 0; i < ready_fill; i++)
          ready_q[i].prio = ready_q[i].rel_tick + ready_q[i].period - now_ticks
                            - ready_q[i].compute;
      end
      default: return;
    endcase
    for (int i = 0; i < ready_fill; i++)
      for (int j = i + 1; j < ready_fill; j++)
        if (ready_q[j].prio < ready_q[i].prio) begin
          t = ready_q[i];
          ready_q[i] = ready_q[j];
          ready_q[j] = t;
        end
  endfunction

  function automatic void release_job(int id, longint rel);
    if (ready_fill >= 16) return;
    ready_q[ready_fill].id        = id[2:0];
    ready_q[ready_fill].period    = period_of(id);
    ready_q[ready_fill].compute   = compute_of(id);
    ready_q[ready_fill].remaining = compute_of(id);
    ready_q[ready_fill].rel_tick  = rel;
    ready_q[ready_fill].prio      = period_of(id);
    ready_fill++;
  endfunction

  // Apply one accepted command to the model; a tick queues its report.
  function automatic void schedule_cmd(plan_step_t c);
    tick_report_t r;
    longint l;
    bit sat;
    case (c.req)
      REQ_LOAD: begin
        period_tab[c.slot]  = c.period;
        compute_tab[c.slot] = c.compute;
      end
      REQ_START: begin
        ready_fill = 0;
        now_ticks  = 0;
        miss_seen  = 1'b0;
        end_seen   = 1'b0;
        hyper_len  = 1;
        sat = 1'b0;
        for (int i = 0; i < active_count(); i++) begin
          release_job(i, 0);
          if (!sat) begin
            l = hyper_len / gcd(hyper_len, period_of(i)) * period_of(i);
            if (l > 65535) begin
              sat = 1'b1;
              l = 65535;
            end
            hyper_len = l;
          end
        end
        reorder_ready();
      end
      REQ_TICK: begin
        r.run_id = '0;
        r.idle   = 1'b1;
        if (!miss_seen && !end_seen) begin
          now_ticks = (now_ticks + 1) & 64'hFFFF;
          if (ready_fill > 0) begin
            r.run_id = ready_q[0].id;
            r.idle   = 1'b0;
            if (ready_q[0].remaining > 0) ready_q[0].remaining--;
            if (ready_q[0].remaining == 0) begin
              for (int k = 0; k < ready_fill - 1; k++) ready_q[k] = ready_q[k + 1];
              ready_fill--;
            end
          end
          for (int i = 0; i < active_count(); i++)
            if (now_ticks % period_of(i) == 0) release_job(i, now_ticks);
          if (now_ticks == hyper_len) end_seen = 1'b1;
          for (int i = 0; i < ready_fill; i++)
            for (int j = i + 1; j < ready_fill; j++)
              if (ready_q[i].id == ready_q[j].id) miss_seen = 1'b1;
          reorder_ready();
        end
        r.missed = miss_seen;
        r.fin    = end_seen;
        r.now    = now_ticks[15:0];
        expected_reports.push_back(r);
      end
      default: ;
    endcase
  endfunction

  // Plan builders.
  function automatic void add_cmd(logic [1:0] req, logic [2:0] slot,
                                  logic [15:0] per, logic [15:0] comp, bit quiet);
    plan_step_t s;
    s = '{kind: STEP_CMD, req: req, slot: slot, period: per, compute: comp,
          reg_index: CFG_POLICY, reg_value: '0, quiet: quiet};
    plan.push_back(s);
    cmds_sent++;
  endfunction

  function automatic void add_cfg(logic idx, logic [3:0] val);
    plan_step_t s;
    s = '{kind: STEP_CFG, req: REQ_NONE, slot: '0, period: '0, compute: '0,
          reg_index: idx, reg_value: val, quiet: 1'b0};
    plan.push_back(s);
  endfunction

  function automatic void add_drain();
    plan_step_t s;
    s = '{kind: STEP_DRAIN, req: REQ_NONE, slot: '0, period: '0, compute: '0,
          reg_index: CFG_POLICY, reg_value: '0, quiet: 1'b0};
    plan.push_back(s);
  endfunction

  // Mostly short periods so jobs release, preempt and collide often; now and
  // then a full 16-bit value to exercise saturation of the hyperperiod.
  function automatic logic [15:0] pick_period();
    if ($urandom_range(0, 15) == 0) return $urandom_range(0, 65535);
    return $urandom_range(1, 12);
  endfunction

  function automatic logic [15:0] pick_compute();
    if ($urandom_range(0, 15) == 0) return $urandom_range(0, 65535);
    return $urandom_range(1, 4);
  endfunction

  // Driver: one command is offered at a time and held until the unit takes
  // it. The model is updated at the accepting edge. start and cfg_we are
  // assigned exactly once per clock edge.
  bit          holding = 1'b0;
  bit          draining = 1'b0;
  int          drain_pause = 0;
  int          idle_gap = 0;
  plan_step_t  cur_cmd;

  always @(posedge clk) begin : driver
    plan_step_t s;
    logic       we_next;
    if (rst) begin
      start  <= 1'b0;
      cfg_we <= 1'b0;
    end else begin
      we_next = 1'b0;
      if (start && !busy) begin
        schedule_cmd(cur_cmd);
        holding = 1'b0;
      end
      if (!holding) begin
        if (draining) begin
          if (expected_reports.size() == 0 && !busy) begin
            if (drain_pause > 0) drain_pause--;
            else draining = 1'b0;
          end
        end else if (idle_gap > 0) begin
          idle_gap--;
        end else if (plan.size() > 0) begin
          s = plan.pop_front();
          case (s.kind)
            STEP_CMD: begin
              cur_cmd = s;
              holding = 1'b1;
              req_type     <= s.req;
              task_slot    <= s.slot;
              task_period  <= s.period;
              task_compute <= s.compute;
              if (!s.quiet && $urandom_range(0, 3) == 0) idle_gap = $urandom_range(1, 5);
            end
            STEP_CFG: begin
              // Nothing is in flight here, so the model takes the new
              // setting at once.
              we_next = 1'b1;
              cfg_index <= s.reg_index;
              cfg_data  <= s.reg_value;
              if (s.reg_index == CFG_POLICY) sched_policy = policy_t'(s.reg_value[1:0]);
              else task_num = s.reg_value;
            end
            default: begin
              // Long enough for the slowest tick or start to run out after
              // its last report.
              draining = 1'b1;
              drain_pause = 400;
            end
          endcase
        end else begin
          all_sent = 1'b1;
        end
      end
      start  <= holding;
      cfg_we <= we_next;
    end
  end

  // Monitor: each done pulse is one tick report, checked against the oldest
  // expectation.
  always @(posedge clk) begin : monitor
    tick_report_t e;
    if (!rst && done) begin
      reports_seen++;
      if (expected_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected tick report: task %0d idle %0b miss %0b fin %0b time %0d",
                   running_task, cpu_idle, deadline_missed, finished, current_time);
      end else begin
        e = expected_reports.pop_front();
        if (running_task !== e.run_id || cpu_idle !== e.idle ||
            deadline_missed !== e.missed || finished !== e.fin ||
            current_time !== e.now) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"tick report mismatch: exp task %0d idle %0b miss %0b fin %0b ",
                      "time %0d, got task %0d idle %0b miss %0b fin %0b time %0d"},
                     e.run_id, e.idle, e.missed, e.fin, e.now, running_task, cpu_idle,
                     deadline_missed, finished, current_time);
        end
      end
    end
  end

  // Main sequence: build the plan, wait for it to play out, and judge.
  initial begin : main
    int ticks;
    int loads;
    // Model reset state.
    for (int i = 0; i < 8; i++) begin
      period_tab[i]  = 0;
      compute_tab[i] = 0;
    end
    ready_fill   = 0;
    now_ticks    = 0;
    hyper_len    = 1;
    miss_seen    = 1'b0;
    end_seen     = 1'b0;
    sched_policy = POL_RM;
    task_num     = 1;

    // Directed part. Every table slot is written before anything reads it.
    add_drain();
    add_cmd(REQ_LOAD, 3'd0, 16'hFFFF, 16'hFFFF, 1'b0);
    add_cmd(REQ_LOAD, 3'd7, 16'h0000, 16'h0000, 1'b0);
    for (int i = 1; i < 7; i++) add_cmd(REQ_LOAD, i[2:0], 16'(i + 1), 16'd1, 1'b0);
    // A tick before any start runs on the reset state; an unknown request
    // is ignored.
    add_cmd(REQ_TICK, 3'd0, 16'd0, 16'd0, 1'b0);
    add_cmd(REQ_NONE, 3'd5, 16'hFFFF, 16'hFFFF, 1'b0);
    add_drain();
    // All eight tasks, with an oversized count: the hyperperiod saturates.
    add_cfg(CFG_TASK_COUNT, 4'd15);
    add_cfg(CFG_POLICY, 4'(POL_EDF));
    add_cmd(REQ_START, 3'd0, 16'd0, 16'd0, 1'b0);
    for (int i = 0; i < 4; i++) add_cmd(REQ_TICK, 3'd0, 16'd0, 16'd0, 1'b0);
    add_drain();
    // No tasks at all: hyperperiod one, so the first tick finishes the run
    // and later ticks change nothing.
    add_cfg(CFG_TASK_COUNT, 4'd0);
    add_cfg(CFG_POLICY, 4'(POL_FIFO));
    add_cmd(REQ_START, 3'd0, 16'd0, 16'd0, 1'b0);
    for (int i = 0; i < 3; i++) add_cmd(REQ_TICK, 3'd0, 16'd0, 16'd0, 1'b0);

    // Random phases: a setting, a few table writes, a start and a run of
    // ticks, with some noise and the odd restart or rewrite mid-run.
    while (cmds_sent < 850) begin
      add_drain();
      phases_run++;
      add_cfg(CFG_POLICY, 4'(phases_run % 4));
      add_cfg(CFG_TASK_COUNT, ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15))
                                                           : 4'($urandom_range(1, 8)));
      loads = $urandom_range(1, 8);
      for (int i = 0; i < loads; i++)
        add_cmd(REQ_LOAD, 3'($urandom_range(0, 7)), pick_period(), pick_compute(),
                cmds_sent > 750);
      add_cmd(REQ_START, 3'($urandom), 16'($urandom), 16'($urandom), cmds_sent > 750);
      ticks = $urandom_range(10, 40);
      for (int i = 0; i < ticks; i++) begin
        case ($urandom_range(0, 29))
          0: add_cmd(REQ_NONE, 3'($urandom), 16'($urandom), 16'($urandom), cmds_sent > 750);
          1: add_cmd(REQ_LOAD, 3'($urandom_range(0, 7)), pick_period(), pick_compute(),
                     cmds_sent > 750);
          2: add_cmd(REQ_START, 3'($urandom), 16'($urandom), 16'($urandom), cmds_sent > 750);
          default: add_cmd(REQ_TICK, 3'($urandom), 16'($urandom), 16'($urandom),
                           cmds_sent > 750);
        endcase
      end
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    wait (all_sent);
    wait (expected_reports.size() == 0 && !busy);
    repeat (400) @(posedge clk);

    $display("Covered %0d commands over %0d random phases and all four policies,",
             cmds_sent, phases_run);
    $display("with %0d tick reports checked against the scheduler model.", reports_seen);
    if (mismatches == 0 && expected_reports.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches, %0d reports missing", mismatches, expected_reports.size());
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin : watchdog
    #50_000_000;
    $display("timeout with %0d reports outstanding", expected_reports.size());
    $display("TB_ERROR");
    $finish;
  end

endmodule
